### sv/rgbbp_pkg.sv
// ----------------------------------------------------------------------------
// rgbbp_pkg
// Shared widths, layout codes and decode helpers for the BGRA pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbbp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned PosW    = 2;
  localparam int unsigned HeldW   = 24;
  localparam int unsigned LayoutW = 3;

  // source byte order codes
  localparam logic [LayoutW-1:0] LayoutBgr  = 3'd0;
  localparam logic [LayoutW-1:0] LayoutBgrx = 3'd1;
  localparam logic [LayoutW-1:0] LayoutRgb  = 3'd2;
  localparam logic [LayoutW-1:0] LayoutRgbx = 3'd3;
  localparam logic [LayoutW-1:0] LayoutRgba = 3'd4;

  localparam logic [ByteW-1:0] AlphaOpaque = 8'hFF;

  // decoded layout
  typedef struct packed {
    logic three_byte;  // 3-byte pixel, else 4
    logic rgb_order;   // red first in the source
    logic has_alpha;   // fourth byte carries alpha
  } layout_t;

  function automatic layout_t decode_layout(input logic [LayoutW-1:0] code);
    layout_t l;
    case (code)
      LayoutBgr:  l = '{three_byte: 1'b1, rgb_order: 1'b0, has_alpha: 1'b0};
      LayoutBgrx: l = '{three_byte: 1'b0, rgb_order: 1'b0, has_alpha: 1'b0};
      LayoutRgb:  l = '{three_byte: 1'b1, rgb_order: 1'b1, has_alpha: 1'b0};
      LayoutRgbx: l = '{three_byte: 1'b0, rgb_order: 1'b1, has_alpha: 1'b0};
      // RGBA and the unused codes above it
      default:    l = '{three_byte: 1'b0, rgb_order: 1'b1, has_alpha: 1'b1};
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

### sv/rgbbp_stream_if.sv
// ----------------------------------------------------------------------------
// rgbbp_stream_if
// Valid/ready channels of the packer: byte input and pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbbp_byte_if
  import rgbbp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_image;

  modport source (output valid, output data_byte, output end_of_image, input ready);
  modport sink   (input valid, input data_byte, input end_of_image, output ready);
endinterface

interface rgbbp_pixel_if
  import rgbbp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] pixel_word;
  logic             last_pixel;

  modport source (output valid, output pixel_word, output last_pixel, input ready);
  modport sink   (input valid, input pixel_word, input last_pixel, output ready);
endinterface

`default_nettype wire

### sv/rgb_byte_stream_to_bgra_packer.sv
// ----------------------------------------------------------------------------
// rgb_byte_stream_to_bgra_packer
// Gathers channel bytes into pixels and emits BGRA8888 words.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                        handshake
//  byte_i    in   data_byte[7:0], end_of_image   valid/ready
//  pixel_o   out  pixel_word[31:0], last_pixel   valid/ready
//  cfg       in   cfg_wdata_i[2:0] (pixel_layout) cfg_we_i, no back-pressure
//
//  One byte is taken per cycle; a pixel word appears in the output register
//  the cycle after its last byte is accepted.
//  Bytes that do not finish a pixel are taken even while a word waits at the
//  output; a finishing byte waits only while the output register is full and
//  not being drained.
//  Reset clears the layout (BGR), the byte position and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_byte_stream_to_bgra_packer
  import rgbbp_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [LayoutW-1:0]  cfg_wdata_i,
  rgbbp_byte_if.sink          byte_i,
  rgbbp_pixel_if.source       pixel_o
);

  // configuration
  logic [LayoutW-1:0] layout_q;
  layout_t            lay;

  // pixel assembly state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [HeldW-1:0] held_q, held_d;

  // output register
  logic             out_valid_q;
  logic [WordW-1:0] out_word_q;
  logic             out_last_q;

  logic             completes;   // this byte finishes a pixel
  logic             in_fire;
  logic             out_free;
  logic [ByteW-1:0] c0, c1, c2, alpha;
  logic [WordW-1:0] word;

  assign lay = decode_layout(layout_q);

  // last byte index is 2 for 3-byte layouts and 3 otherwise; a position at or
  // past it (possible after a layout change) finishes the pixel too
  assign completes = lay.three_byte ? (pos_q >= PosW'(2)) : (pos_q == PosW'(3));

  assign out_free     = !out_valid_q || pixel_o.ready;
  assign byte_i.ready = out_free || !completes;
  assign in_fire      = byte_i.valid && byte_i.ready;

  // channel steering
  always_comb begin
    c0    = held_q[7:0];
    c1    = held_q[15:8];
    c2    = lay.three_byte ? byte_i.data_byte : held_q[23:16];
    alpha = lay.has_alpha ? byte_i.data_byte : AlphaOpaque;
    if (lay.rgb_order) begin
      word = {alpha, c0, c1, c2};
    end else begin
      word = {alpha, c2, c1, c0};
    end
  end

  // position and held bytes
  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    if (in_fire) begin
      if (completes || byte_i.end_of_image) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
      if (!completes) begin
        case (pos_q)
          2'd0:    held_d[7:0]   = byte_i.data_byte;
          2'd1:    held_d[15:8]  = byte_i.data_byte;
          default: held_d[23:16] = byte_i.data_byte;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q    <= LayoutBgr;
      pos_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        layout_q <= cfg_wdata_i;
      end
      pos_q  <= pos_d;
      held_q <= held_d;
      if (in_fire && completes) begin
        out_valid_q <= 1'b1;
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && completes) begin
      out_word_q <= word;
      out_last_q <= byte_i.end_of_image;
    end
  end

  assign pixel_o.valid      = out_valid_q;
  assign pixel_o.pixel_word = out_word_q;
  assign pixel_o.last_pixel = out_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // a finishing byte always lands a word in the output register
  a_complete_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && completes |=> out_valid_q)
    else $error("finished pixel not presented");

  // end of image or a finished pixel restarts the byte position
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (completes || byte_i.end_of_image) |=> pos_q == '0)
    else $error("byte position not restarted");

  // an ordinary byte advances the position by one
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !completes && !byte_i.end_of_image |=> pos_q == $past(pos_q) + PosW'(1))
    else $error("byte position did not advance");

  // a byte that finishes a pixel is never taken while the word slot is blocked
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pixel_o.ready && completes |-> !byte_i.ready)
    else $error("pending word would be overwritten");

endmodule

`default_nettype wire
